// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define PCU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define PCU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PCU_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PCU_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/pcu_pkg.sv =====
// ----------------------------------------------------------------------------
// pcu_pkg
// Types, constants and table helpers for the performance counter unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pcu_pkg;

  // counter bank size and derived widths
  localparam int MAX_COUNTERS = 4;
  localparam int CTR_IDX_W    = (MAX_COUNTERS > 1) ? $clog2(MAX_COUNTERS) : 1;
  localparam int EXP_W        = $clog2(MAX_COUNTERS + 1);

  // item operations
  localparam logic [1:0] OP_READ     = 2'd0;
  localparam logic [1:0] OP_WRITE    = 2'd1;
  localparam logic [1:0] OP_IDX_READ = 2'd2;
  localparam logic [1:0] OP_EVENT    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_COUNT = 2'd0;
  localparam logic [1:0] CFG_WIDTH = 2'd1;
  localparam logic [1:0] CFG_AVAIL = 2'd2;

  // config reset values
  localparam logic [2:0] CFG_COUNT_RST = 3'd4;
  localparam logic [6:0] CFG_WIDTH_RST = 7'd48;
  localparam logic [6:0] CFG_AVAIL_RST = 7'd127;

  // register map
  localparam logic [31:0] CTR_BASE = 32'h0000_00C1;
  localparam logic [31:0] SEL_BASE = 32'h0000_0186;

  // event selector fields
  localparam logic [63:0] SEL_RESERVED = 64'hffff_ffff_0020_0000;
  localparam int SEL_USR_BIT = 16;
  localparam int SEL_OS_BIT  = 17;
  localparam int SEL_INT_BIT = 20;
  localparam int SEL_EN_BIT  = 22;
  localparam int SEL_INV_BIT = 23;

  // architectural event table
  localparam int TABLE_SIZE = 7;
  localparam logic [7:0] EV_CODE [TABLE_SIZE] =
    '{8'h3c, 8'hc0, 8'h3c, 8'h2e, 8'h2e, 8'hc4, 8'hc5};
  localparam logic [7:0] EV_UMASK [TABLE_SIZE] =
    '{8'h00, 8'h00, 8'h01, 8'h4f, 8'h41, 8'h00, 8'h00};

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] msr_address;
    logic [63:0] write_data;
    logic [31:0] pmc_select;
    logic [7:0]  event_code;
    logic [7:0]  event_umask;
    logic        event_user_mode;
  } pcu_in_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic        status;
    logic        overflow_interrupt;
  } pcu_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic commit;
  } pcu_cmd_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] entry;
  } ev_match_t;

  // first available table entry matching code and umask
  function automatic ev_match_t ev_lookup(input logic [7:0] code, input logic [7:0] umask,
                                          input logic [6:0] avail);
    ev_match_t m;
    m = '0;
    for (int e = TABLE_SIZE - 1; e >= 0; e--) begin
      if (EV_CODE[e] == code && EV_UMASK[e] == umask && avail[e]) begin
        m.hit   = 1'b1;
        m.entry = 3'(e);
      end
    end
    return m;
  endfunction

  // does the stored table entry describe this event
  function automatic logic ev_entry_is(input logic [2:0] entry, input logic [7:0] code,
                                       input logic [7:0] umask);
    logic r;
    r = 1'b0;
    if (32'(entry) < TABLE_SIZE)
      r = (EV_CODE[entry] == code) && (EV_UMASK[entry] == umask);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pcu_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcu_ctrl
// Item sequencer: capture, execute, and result register handshake.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pcu_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output pcu_pkg::pcu_cmd_t     cmd
);
  import pcu_pkg::*;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // commands
  assign in_stall      = (state_r != S_IDLE);
  assign cmd.load_item = in_valid && (state_r == S_IDLE);
  assign cmd.commit    = (state_r == S_EXEC) && (!out_valid_r || !out_stall);
  assign out_valid     = out_valid_r;

  // next state
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.load_item) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.commit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // sequencing checks
  `PCU_ASSERT_NXT(a_load_to_exec, clk, rst_n, cmd.load_item, state_r == S_EXEC)
  `PCU_ASSERT_NXT(a_commit_shows, clk, rst_n, cmd.commit, out_valid_r && state_r == S_IDLE)
  `PCU_ASSERT_NXT(a_no_overwrite, clk, rst_n,
                  state_r == S_EXEC && out_valid_r && out_stall, state_r == S_EXEC)

endmodule

`default_nettype wire

// ===== rtl/pcu_datapath.sv =====
// ----------------------------------------------------------------------------
// pcu_datapath
// Config registers, counter and selector state, item decode and result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module pcu_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [6:0]        cfg_data,
  input  wire pcu_pkg::pcu_in_t  in_data,
  input  wire pcu_pkg::pcu_cmd_t cmd,
  output pcu_pkg::pcu_out_t      out_data
);
  import pcu_pkg::*;

  // configuration
  logic [2:0] cfg_count_r;
  logic [6:0] cfg_width_r;
  logic [6:0] cfg_avail_r;

  // captured item and result
  pcu_in_t  item_r;
  pcu_out_t out_r, out_nxt;

  // per-counter state
  logic [63:0] sel_r     [MAX_COUNTERS];
  logic [63:0] sel_nxt   [MAX_COUNTERS];
  logic [63:0] cnt_r     [MAX_COUNTERS];
  logic [63:0] cnt_nxt   [MAX_COUNTERS];
  logic        on_r      [MAX_COUNTERS];
  logic        on_nxt    [MAX_COUNTERS];
  logic [2:0]  entry_r   [MAX_COUNTERS];
  logic [2:0]  entry_nxt [MAX_COUNTERS];
  logic        armed_r   [MAX_COUNTERS];
  logic        armed_nxt [MAX_COUNTERS];

  // decode helpers
  logic [63:0]    mask;
  logic [EXP_W-1:0] exposed;
  logic [31:0]    ctr_off, sel_off;
  logic           ctr_hit, sel_hit, idx_ok;
  logic [CTR_IDX_W-1:0] ctr_idx, sel_idx, pmc_idx;
  ev_match_t      wr_match;
  logic [63:0]    wdata;

  assign mask    = (cfg_width_r >= 7'd64) ? '1 : ((64'd1 << cfg_width_r[5:0]) - 64'd1);
  assign exposed = (32'(cfg_count_r) < 32'(MAX_COUNTERS)) ? EXP_W'(cfg_count_r)
                                                          : EXP_W'(MAX_COUNTERS);
  assign ctr_off = item_r.msr_address - CTR_BASE;
  assign sel_off = item_r.msr_address - SEL_BASE;
  assign ctr_hit = (item_r.msr_address >= CTR_BASE) && (ctr_off < 32'(exposed));
  assign sel_hit = (item_r.msr_address >= SEL_BASE) && (sel_off < 32'(exposed));
  assign idx_ok  = (31'(item_r.pmc_select[30:0]) < 31'(exposed));
  assign ctr_idx = ctr_off[CTR_IDX_W-1:0];
  assign sel_idx = sel_off[CTR_IDX_W-1:0];
  assign pmc_idx = item_r.pmc_select[CTR_IDX_W-1:0];
  assign wdata   = item_r.write_data;
  assign wr_match = ev_lookup(wdata[7:0], wdata[15:8], cfg_avail_r);

  // item execution
  always_comb begin
    logic [63:0] inc_v;
    sel_nxt   = sel_r;
    cnt_nxt   = cnt_r;
    on_nxt    = on_r;
    entry_nxt = entry_r;
    armed_nxt = armed_r;
    out_nxt   = '0;
    inc_v     = '0;
    case (item_r.operation)
      OP_READ: begin
        if (ctr_hit)      out_nxt.read_data = cnt_r[ctr_idx] & mask;
        else if (sel_hit) out_nxt.read_data = sel_r[sel_idx];
        else              out_nxt.status    = 1'b1;
      end
      OP_WRITE: begin
        if (ctr_hit) begin
          cnt_nxt[ctr_idx] = {{32{wdata[31]}}, wdata[31:0]} & mask;
        end else if (sel_hit) begin
          if (wdata == sel_r[sel_idx]) begin
            out_nxt.status = 1'b0;
          end else if (|(wdata & SEL_RESERVED)) begin
            out_nxt.status = 1'b1;
          end else begin
            sel_nxt[sel_idx]   = wdata;
            on_nxt[sel_idx]    = 1'b0;
            armed_nxt[sel_idx] = 1'b0;
            if (wdata[SEL_EN_BIT]) begin
              if (!wr_match.hit) begin
                out_nxt.status = 1'b1;
              end else begin
                entry_nxt[sel_idx] = wr_match.entry;
                if (!wdata[SEL_INV_BIT] && wdata[31:24] <= 8'd1) begin
                  on_nxt[sel_idx]    = 1'b1;
                  armed_nxt[sel_idx] = wdata[SEL_INT_BIT];
                end
              end
            end
          end
        end else begin
          out_nxt.status = 1'b1;
        end
      end
      OP_IDX_READ: begin
        if (!idx_ok) begin
          out_nxt.status = 1'b1;
        end else begin
          out_nxt.read_data = cnt_r[pmc_idx] & mask;
          if (item_r.pmc_select[31]) out_nxt.read_data[63:32] = '0;
        end
      end
      OP_EVENT: begin
        // every exposed counter checks the event on its own
        for (int i = 0; i < MAX_COUNTERS; i++) begin
          if (32'(i) < 32'(exposed) && on_r[i] &&
              ev_entry_is(entry_r[i], item_r.event_code, item_r.event_umask) &&
              (item_r.event_user_mode ? sel_r[i][SEL_USR_BIT] : sel_r[i][SEL_OS_BIT])) begin
            inc_v      = (cnt_r[i] + 64'd1) & mask;
            cnt_nxt[i] = inc_v;
            if (inc_v == '0 && armed_r[i]) begin
              out_nxt.overflow_interrupt = 1'b1;
              armed_nxt[i]               = 1'b0;
            end
          end
        end
      end
      default: out_nxt = '0;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r <= CFG_COUNT_RST;
      cfg_width_r <= CFG_WIDTH_RST;
      cfg_avail_r <= CFG_AVAIL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COUNT: cfg_count_r <= cfg_data[2:0];
        CFG_WIDTH: cfg_width_r <= cfg_data;
        CFG_AVAIL: cfg_avail_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // counter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_COUNTERS; i++) begin
        sel_r[i]   <= '0;
        cnt_r[i]   <= '0;
        on_r[i]    <= 1'b0;
        entry_r[i] <= '0;
        armed_r[i] <= 1'b0;
      end
    end else if (cmd.commit) begin
      sel_r   <= sel_nxt;
      cnt_r   <= cnt_nxt;
      on_r    <= on_nxt;
      entry_r <= entry_nxt;
      armed_r <= armed_nxt;
    end
  end

  // item capture and result register
  always_ff @(posedge clk) begin
    if (cmd.load_item) item_r <= in_data;
    if (cmd.commit)    out_r  <= out_nxt;
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

// ===== rtl/performance_counter_unit.sv =====
// ----------------------------------------------------------------------------
// performance_counter_unit
// Architectural performance monitor with counters and event selectors.
// ----------------------------------------------------------------------------
// Each item is captured in the idle state and then executed in the execute
// state, in which the datapath decodes it, updates counter and selector state
// and loads the single result register. A new item is taken once the previous
// one has executed, so the unit never accepts an item while one is in flight;
// a stalled result holds the execute state until the result register frees
// up. Configuration writes land on the next clock.
`default_nettype none

module performance_counter_unit (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [6:0]       cfg_data,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire pcu_pkg::pcu_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output pcu_pkg::pcu_out_t     out_data
);
  import pcu_pkg::*;

  pcu_cmd_t cmd;

  // sequencer
  pcu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // state and decode
  pcu_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives register reads and writes, indexed counter reads and event items
// into the performance counter unit under several register settings and
// idle patterns, and checks every result against an in-bench copy of the
// counter and selector state.
// ----------------------------------------------------------------------------

module testbench;
  import pcu_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PHASE = 95;
  localparam int PHASES = 8;

  // architectural event table: code and unit mask per entry
  localparam logic [0:6][7:0] EVT_CODE  = {8'h3c, 8'hc0, 8'h3c, 8'h2e, 8'h2e, 8'hc4, 8'hc5};
  localparam logic [0:6][7:0] EVT_UMASK = {8'h00, 8'h00, 8'h01, 8'h4f, 8'h41, 8'h00, 8'h00};

  // selector values used by the directed items
  localparam logic [63:0] SEL_LOOP_IRQ  = 64'h0000_0000_0053_003c;
  localparam logic [63:0] SEL_BIT21     = 64'h0000_0000_0073_003c;
  localparam logic [63:0] SEL_HIGH      = 64'h0000_0001_0053_003c;
  localparam logic [63:0] SEL_UNKNOWN   = 64'h0000_0000_0043_0012;
  localparam logic [63:0] SEL_INVERTED  = 64'h0000_0000_00c3_00c0;
  localparam logic [63:0] SEL_CMASK2    = 64'h0000_0000_0243_00c4;
  localparam logic [63:0] SEL_USER_EDGE = 64'h0000_0000_0045_412e;
  localparam logic [63:0] SEL_OFF       = 64'h0000_0000_0013_003c;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_COUNT;
  logic [6:0] cfg_data = '0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  pcu_in_t   in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  pcu_out_t  out_data;

  performance_counter_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // shadow of the unit: register settings and per-counter state
  logic [2:0]  cnt_cfg   = CFG_COUNT_RST;
  logic [6:0]  width_cfg = CFG_WIDTH_RST;
  logic [6:0]  avail_cfg = CFG_AVAIL_RST;
  logic [63:0] sel_q   [MAX_COUNTERS] = '{default: '0};
  logic [63:0] count_q [MAX_COUNTERS] = '{default: '0};
  logic        on_q    [MAX_COUNTERS] = '{default: 1'b0};
  logic [2:0]  entry_q [MAX_COUNTERS] = '{default: '0};
  logic        armed_q [MAX_COUNTERS] = '{default: 1'b0};

  pcu_in_t  item_backlog [$];
  pcu_out_t due_results [$];
  pcu_out_t want_r;
  int       errors = 0;
  int       cycle_count = 0;
  int       idle_pct = 0;
  int       stall_pct = 0;
  logic [63:0] sel_last [5] = '{default: '0};

  int phase_count [PHASES] = '{4, 4, 4, 2, 0, 3, 4, 1};
  int phase_width [PHASES] = '{48, 1, 64, 8, 32, 3, 2, 16};
  int phase_avail [PHASES] = '{127, 127, 127, 85, 127, 0, 127, 42};

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic int shown_ctrs();
    return (int'(cnt_cfg) < MAX_COUNTERS) ? int'(cnt_cfg) : MAX_COUNTERS;
  endfunction

  function automatic logic [63:0] width_mask_now();
    if (width_cfg >= 7'd64) return '1;
    return (64'd1 << width_cfg) - 64'd1;
  endfunction

  // index into a bank, -1 outside its exposed part
  function automatic int bank_of(input logic [31:0] addr, input logic [31:0] base);
    if (addr >= base && (addr - base) < 32'(shown_ctrs())) return int'(addr - base);
    return -1;
  endfunction

  // selector write; returns the fault flag
  function automatic logic store_selector(input int i, input logic [63:0] d);
    int hit;
    hit = -1;
    if (d == sel_q[i]) return 1'b0;
    if ((d & SEL_RESERVED) != 64'd0) return 1'b1;
    sel_q[i]   = d;
    on_q[i]    = 1'b0;
    armed_q[i] = 1'b0;
    if (!d[SEL_EN_BIT]) return 1'b0;
    for (int e = 6; e >= 0; e--) begin
      if (EVT_CODE[e] == d[7:0] && EVT_UMASK[e] == d[15:8] && avail_cfg[e]) hit = e;
    end
    if (hit < 0) return 1'b1;
    entry_q[i] = 3'(hit);
    // inverted or cmask above one: stored but never counts
    if (d[SEL_INV_BIT] || d[31:24] > 8'd1) return 1'b0;
    on_q[i]    = 1'b1;
    armed_q[i] = d[SEL_INT_BIT];
    return 1'b0;
  endfunction

  function automatic pcu_out_t pmu_answer(input pcu_in_t it);
    pcu_out_t    r;
    logic [63:0] m;
    logic [31:0] idx;
    int          i;
    int          e;
    r = '0;
    m = width_mask_now();
    case (it.operation)
      OP_READ: begin
        i = bank_of(it.msr_address, CTR_BASE);
        if (i >= 0) begin
          r.read_data = count_q[i] & m;
        end else begin
          i = bank_of(it.msr_address, SEL_BASE);
          if (i >= 0) r.read_data = sel_q[i];
          else r.status = 1'b1;
        end
      end
      OP_WRITE: begin
        i = bank_of(it.msr_address, CTR_BASE);
        if (i >= 0) begin
          count_q[i] = {{32{it.write_data[31]}}, it.write_data[31:0]} & m;
        end else begin
          i = bank_of(it.msr_address, SEL_BASE);
          if (i >= 0) r.status = store_selector(i, it.write_data);
          else r.status = 1'b1;
        end
      end
      OP_IDX_READ: begin
        idx = {1'b0, it.pmc_select[30:0]};
        if (idx >= 32'(shown_ctrs())) begin
          r.status = 1'b1;
        end else begin
          r.read_data = count_q[idx] & m;
          if (it.pmc_select[31]) r.read_data[63:32] = '0;
        end
      end
      default: begin
        for (i = 0; i < shown_ctrs(); i++) begin
          e = int'(entry_q[i]);
          if (on_q[i] && e < 7 && EVT_CODE[e] == it.event_code &&
              EVT_UMASK[e] == it.event_umask &&
              sel_q[i][it.event_user_mode ? SEL_USR_BIT : SEL_OS_BIT]) begin
            count_q[i] = (count_q[i] + 64'd1) & m;
            if (count_q[i] == 64'd0 && armed_q[i]) begin
              r.overflow_interrupt = 1'b1;
              armed_q[i] = 1'b0;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // item builders: unused fields carry random bits
  // ---------------------------------------------------------------------------
  function automatic pcu_in_t noise_item(input logic [1:0] op);
    pcu_in_t it;
    it = $bits(pcu_in_t)'({$urandom, $urandom, $urandom, $urandom, $urandom});
    it.operation = op;
    return it;
  endfunction

  function automatic pcu_in_t access_item(input logic [1:0] op, input logic [31:0] addr,
                                          input logic [63:0] d);
    pcu_in_t it;
    it = noise_item(op);
    it.msr_address = addr;
    it.write_data  = d;
    return it;
  endfunction

  function automatic pcu_in_t idx_item(input logic [31:0] sel);
    pcu_in_t it;
    it = noise_item(OP_IDX_READ);
    it.pmc_select = sel;
    return it;
  endfunction

  function automatic pcu_in_t event_item(input logic [7:0] code, input logic [7:0] umask,
                                         input logic user);
    pcu_in_t it;
    it = noise_item(OP_EVENT);
    it.event_code      = code;
    it.event_umask     = umask;
    it.event_user_mode = user;
    return it;
  endfunction

  function automatic logic [31:0] pick_addr(input logic [31:0] base);
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return base - 32'd1;
      default: return base + $urandom_range(0, 4);
    endcase
  endfunction

  function automatic logic [63:0] pick_selector();
    logic [63:0] d;
    int          e;
    d = '0;
    e = $urandom_range(0, 6);
    if ($urandom_range(99) < 85) d[15:0] = {EVT_UMASK[e], EVT_CODE[e]};
    else d[15:0] = 16'($urandom);
    d[SEL_USR_BIT] = ($urandom_range(99) < 70);
    d[SEL_OS_BIT]  = ($urandom_range(99) < 70);
    d[19:18]       = 2'($urandom);
    d[SEL_INT_BIT] = 1'($urandom_range(1));
    d[SEL_EN_BIT]  = ($urandom_range(99) < 85);
    d[SEL_INV_BIT] = ($urandom_range(99) < 8);
    case ($urandom_range(9))
      0:       d[31:24] = 8'($urandom);
      1:       d[31:24] = 8'd1;
      default: d[31:24] = 8'd0;
    endcase
    if ($urandom_range(99) < 5) d[21] = 1'b1;
    if ($urandom_range(99) < 5) d[63:32] = $urandom;
    return d;
  endfunction

  function automatic pcu_in_t random_item();
    pcu_in_t     it;
    logic [31:0] a;
    logic [63:0] d;
    int          k;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      it = access_item(OP_READ, pick_addr($urandom_range(1) ? CTR_BASE : SEL_BASE), 64'($urandom));
    end else if (pick < 27) begin
      // counter writes, mostly close to a wrap
      case ($urandom_range(4))
        0:       d = {$urandom, 32'hffff_ffff};
        1:       d = {$urandom, 32'hffff_fffe};
        2:       d = {$urandom, 32'h7fff_ffff};
        default: d = {$urandom, $urandom};
      endcase
      it = access_item(OP_WRITE, pick_addr(CTR_BASE), d);
    end else if (pick < 47) begin
      a = pick_addr(SEL_BASE);
      k = int'(a - SEL_BASE);
      d = pick_selector();
      if (k >= 0 && k < 5) begin
        if ($urandom_range(99) < 15) d = sel_last[k];
        sel_last[k] = d;
      end
      it = access_item(OP_WRITE, a, d);
    end else if (pick < 57) begin
      if ($urandom_range(9) == 0) a = $urandom;
      else a = {1'($urandom), 31'($urandom_range(0, 5))};
      it = idx_item(a);
    end else if (pick < 92) begin
      k = $urandom_range(0, 6);
      if ($urandom_range(9) == 0)
        it = event_item(8'($urandom), 8'($urandom), 1'($urandom_range(1)));
      else it = event_item(EVT_CODE[k], EVT_UMASK[k], 1'($urandom_range(1)));
    end else begin
      it = noise_item(2'($urandom));
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // clock, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // driver: predicts each accepted item, then offers the next one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) due_results.push_back(pmu_answer(in_data));
      if (!in_valid || !in_stall) begin
        if (item_backlog.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_data  <= item_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random stall, in-order compare
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $display("%0t: result with none expected: actual %h", $time, out_data);
        errors++;
      end else begin
        want_r = due_results.pop_front();
        if (out_data.read_data !== want_r.read_data) begin
          $display("%0t: read_data expected %h actual %h", $time, want_r.read_data,
                   out_data.read_data);
          errors++;
        end
        if (out_data.status !== want_r.status) begin
          $display("%0t: status expected %b actual %b", $time, want_r.status, out_data.status);
          errors++;
        end
        if (out_data.overflow_interrupt !== want_r.overflow_interrupt) begin
          $display("%0t: overflow_interrupt expected %b actual %b", $time,
                   want_r.overflow_interrupt, out_data.overflow_interrupt);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  task automatic write_cfg(input logic [1:0] idx, input int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 7'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_COUNT: cnt_cfg   = 3'(val);
      CFG_WIDTH: width_cfg = 7'(val);
      default:   avail_cfg = 7'(val);
    endcase
  endtask

  task automatic drain();
    while (item_backlog.size() != 0 || in_valid || due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: faults, sign extension, fast read, selector cases, wrap
    item_backlog.push_back(access_item(OP_READ, CTR_BASE, 64'd0));
    item_backlog.push_back(access_item(OP_READ, SEL_BASE, 64'd0));
    item_backlog.push_back(access_item(OP_READ, CTR_BASE + 32'd4, 64'd0));
    item_backlog.push_back(access_item(OP_WRITE, 32'hffff_ffff, '1));
    item_backlog.push_back(idx_item(32'd4));
    item_backlog.push_back(access_item(OP_WRITE, CTR_BASE, 64'h1234_5678_8000_0000));
    item_backlog.push_back(idx_item(32'h8000_0000));
    item_backlog.push_back(idx_item(32'd0));
    item_backlog.push_back(access_item(OP_WRITE, SEL_BASE, SEL_BIT21));
    item_backlog.push_back(access_item(OP_WRITE, SEL_BASE, SEL_HIGH));
    item_backlog.push_back(access_item(OP_WRITE, SEL_BASE, SEL_LOOP_IRQ));
    item_backlog.push_back(access_item(OP_WRITE, SEL_BASE, SEL_LOOP_IRQ));
    item_backlog.push_back(access_item(OP_WRITE, SEL_BASE + 32'd1, SEL_UNKNOWN));
    item_backlog.push_back(access_item(OP_READ, SEL_BASE + 32'd1, 64'd0));
    item_backlog.push_back(access_item(OP_WRITE, SEL_BASE + 32'd2, SEL_INVERTED));
    item_backlog.push_back(access_item(OP_WRITE, SEL_BASE + 32'd3, SEL_CMASK2));
    item_backlog.push_back(access_item(OP_WRITE, CTR_BASE, 64'h0000_0000_ffff_ffff));
    item_backlog.push_back(event_item(8'h3c, 8'h00, 1'b1));
    item_backlog.push_back(event_item(8'h3c, 8'h00, 1'b0));
    item_backlog.push_back(access_item(OP_READ, CTR_BASE, 64'd0));
    item_backlog.push_back(access_item(OP_WRITE, SEL_BASE + 32'd1, SEL_USER_EDGE));
    item_backlog.push_back(event_item(8'h2e, 8'h41, 1'b0));
    item_backlog.push_back(event_item(8'h2e, 8'h41, 1'b1));
    item_backlog.push_back(event_item(8'hc0, 8'h00, 1'b1));
    item_backlog.push_back(event_item(8'hc4, 8'h00, 1'b1));
    item_backlog.push_back(idx_item(32'h8000_0003));
    item_backlog.push_back(access_item(OP_WRITE, SEL_BASE, SEL_OFF));
    item_backlog.push_back(event_item(8'h3c, 8'h00, 1'b1));
    item_backlog.push_back(access_item(OP_READ, CTR_BASE + 32'd1, 64'd0));
    drain();

    // random phases, each under its own settings and idle pattern
    for (int p = 0; p < PHASES; p++) begin
      write_cfg(CFG_COUNT, phase_count[p]);
      write_cfg(CFG_WIDTH, phase_width[p]);
      write_cfg(CFG_AVAIL, phase_avail[p]);
      repeat (2) @(posedge clk);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) item_backlog.push_back(random_item());
      drain();
    end

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
